[src/ptcc_pkg.sv]
// ----------------------------------------------------------------------------
// ptcc_pkg
// Shared widths, register indexes, reset values, the result word type and the
// configuration type of the per-channel timestamp continuity check.
// ----------------------------------------------------------------------------
package ptcc_pkg;

   // field widths
   localparam int unsigned CHANNEL_W   = 6;
   localparam int unsigned TS_W        = 64;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned STEP_W      = 32;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_EMULATE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_STEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LIMIT   = 2'd2;

   // register reset values
   localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd4096;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 32'd1000;

   // one result word
   typedef struct packed {
      logic [TS_W-1:0]    used_timestamp;
      logic               gap_found;
      logic [TS_W-1:0]    gap_start;
      logic [TS_W-1:0]    gap_end;
      logic               first_mismatch;
      logic               broken;
      logic [COUNT_W-1:0] error_count;
   } rsp_word_type;

   // active configuration seen by the check logic
   typedef struct packed {
      logic               emulate_mode;
      logic [STEP_W-1:0]  expected_step;
      logic [COUNT_W-1:0] error_limit;
   } cfg_type;

endpackage

[src/ptcc_stamp_ram.sv]
// ----------------------------------------------------------------------------
// ptcc_stamp_ram
// Last-timestamp table: one synchronous read port with registered data, one
// write port, and a clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module ptcc_stamp_ram
   import ptcc_pkg::*;
#(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [TS_W-1:0] rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [TS_W-1:0] wr_data,
   output logic            busy
);

   logic [TS_W-1:0] mem [DEPTH];
   logic [TS_W-1:0] rd_data_ff;
   logic [AW-1:0]   clr_ptr_ff;
   logic [AW-1:0]   clr_ptr_in;
   logic            busy_ff;
   logic            busy_in;

   // clear sweep control
   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      busy_in    = busy_ff;
      if (busy_ff) begin
         if (clr_ptr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_ptr_in = clr_ptr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         busy_ff    <= 1'b1;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         busy_ff    <= busy_in;
      end
   end

   // table write, zero during the sweep
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

[src/ptcc_check.sv]
// ----------------------------------------------------------------------------
// ptcc_check
// Continuity test of one word against its channel's previous timestamp, with
// the saturating error counter, the first-mismatch flag and the broken flag.
// ----------------------------------------------------------------------------
module ptcc_check
   import ptcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            commit,
   input  cfg_type         cfg,
   input  logic [TS_W-1:0] timestamp,
   input  logic [TS_W-1:0] prev_stamp,
   output rsp_word_type    result
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               mismatch_ff;
   logic               mismatch_in;
   logic               broken_ff;
   logic               broken_in;

   logic [TS_W-1:0] step_ext;
   logic            seen;
   logic [TS_W-1:0] next_expected;
   logic [TS_W-1:0] fresh_emulated;
   logic [TS_W-1:0] used;
   logic            gap;

   // datapath: expected stamp and gap test
   always_comb begin
      step_ext       = TS_W'(cfg.expected_step);
      seen           = (prev_stamp != '0);
      next_expected  = prev_stamp + step_ext;
      fresh_emulated = timestamp + step_ext;
      if (cfg.emulate_mode) begin
         used = seen ? next_expected : fresh_emulated;
      end else begin
         used = timestamp;
      end
      gap = !cfg.emulate_mode && seen && ((timestamp - prev_stamp) != step_ext);
   end

   // statistics next state
   always_comb begin
      count_in    = count_ff;
      mismatch_in = mismatch_ff || gap;
      if (gap && (count_ff != '1)) begin
         count_in = count_ff + COUNT_W'(1);
      end
      broken_in = broken_ff || (count_in > cfg.error_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         mismatch_ff <= 1'b0;
         broken_ff   <= 1'b0;
      end else if (commit) begin
         count_ff    <= count_in;
         mismatch_ff <= mismatch_in;
         broken_ff   <= broken_in;
      end
   end

   // result word
   always_comb begin
      result.used_timestamp = used;
      result.gap_found      = gap;
      result.gap_start      = gap ? next_expected : '0;
      result.gap_end        = gap ? timestamp : '0;
      result.first_mismatch = gap && !mismatch_ff;
      result.broken         = broken_in;
      result.error_count    = count_in;
   end

   // broken flag is sticky
   a_broken_sticky: assert property (@(posedge clock) disable iff (reset)
      broken_ff |=> broken_ff)
      else $error("broken flag cleared without reset");

   // error counter never goes back
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff >= $past(count_ff)))
      else $error("error counter decreased");

   // a recorded mismatch means a counted error
   a_mismatch_counted: assert property (@(posedge clock) disable iff (reset)
      mismatch_ff |-> (count_ff != '0))
      else $error("mismatch seen with zero error count");

endmodule

[src/per_channel_timestamp_continuity_check_core.sv]
// ----------------------------------------------------------------------------
// per_channel_timestamp_continuity_check_core
// Checks that frame timestamps on each channel advance by a fixed step and
// reports gaps, error count and a sticky broken flag, or emulates stamps.
// ----------------------------------------------------------------------------
// One request word (channel, timestamp) is taken per clock unless the table
// sweep or a blocked check stage stalls it; the word is registered in the check
// stage and its result word in the output register, so a stalled result lets
// one more request enter. The rate is set by the per-channel table: one read
// and one write-back per word, with the write of the previous word forwarded
// to a following word on the same channel. After reset the table is swept to
// zero, one entry a cycle; requests are stalled during the sweep while
// register writes are taken as usual. Channel numbers wrap modulo CHANNELS.
module per_channel_timestamp_continuity_check_core
   import ptcc_pkg::*;
#(
   parameter int unsigned CHANNELS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CHANNEL_W-1:0]   req_channel,
   input  logic [TS_W-1:0]        req_timestamp,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [TS_W-1:0]        rsp_used_timestamp,
   output logic                   rsp_gap_found,
   output logic [TS_W-1:0]        rsp_gap_start,
   output logic [TS_W-1:0]        rsp_gap_end,
   output logic                   rsp_first_mismatch,
   output logic                   rsp_broken,
   output logic [COUNT_W-1:0]     rsp_error_count
);

   localparam int unsigned IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CH_COUNT = 1 << CHANNEL_W;

   cfg_type         cfg_ff;
   logic            s1_valid_ff;
   logic [IDX_W-1:0] s1_idx_ff;
   logic [TS_W-1:0] s1_ts_ff;
   logic            fwd_hit_ff;
   logic [TS_W-1:0] fwd_val_ff;
   logic            rsp_valid_ff;
   rsp_word_type    rsp_ff;

   logic            s1_valid_in;
   logic            rsp_valid_in;
   logic            out_free;
   logic            s1_move;
   logic            req_take;
   logic            clear_busy;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] chan_map [CH_COUNT];
   logic [TS_W-1:0] ram_rdata;
   logic [TS_W-1:0] prev_stamp;
   rsp_word_type    result;

   // channel number to table index, a constant map over every channel code
   for (genvar g = 0; g < CH_COUNT; g++) begin : g_chan_map
      assign chan_map[g] = IDX_W'(g % CHANNELS);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emulate_mode  <= 1'b0;
         cfg_ff.expected_step <= STEP_RESET;
         cfg_ff.error_limit   <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_EMULATE_MODE: begin
               cfg_ff.emulate_mode <= csr_wdata[0];
            end
            CSR_EXPECTED_STEP: begin
               cfg_ff.expected_step <= csr_wdata[STEP_W-1:0];
            end
            CSR_ERROR_LIMIT: begin
               cfg_ff.error_limit <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake and stage advance
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = clear_busy || (s1_valid_ff && !out_free);
   assign req_take  = req_valid && !req_stall;
   assign req_idx   = chan_map[req_channel];

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // check stage word and forwarding of the word committing this cycle
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_idx_ff  <= req_idx;
         s1_ts_ff   <= req_timestamp;
         fwd_hit_ff <= s1_move && (s1_idx_ff == req_idx);
         fwd_val_ff <= result.used_timestamp;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff <= result;
      end
   end

   ptcc_stamp_ram #(
      .DEPTH (CHANNELS),
      .AW    (IDX_W)
   ) u_stamp_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (req_idx),
      .rd_data (ram_rdata),
      .wr_en   (s1_move),
      .wr_addr (s1_idx_ff),
      .wr_data (result.used_timestamp),
      .busy    (clear_busy)
   );

   assign prev_stamp = fwd_hit_ff ? fwd_val_ff : ram_rdata;

   ptcc_check u_check (
      .clock      (clock),
      .reset      (reset),
      .commit     (s1_move),
      .cfg        (cfg_ff),
      .timestamp  (s1_ts_ff),
      .prev_stamp (prev_stamp),
      .result     (result)
   );

   // result ports
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_used_timestamp = rsp_ff.used_timestamp;
   assign rsp_gap_found      = rsp_ff.gap_found;
   assign rsp_gap_start      = rsp_ff.gap_start;
   assign rsp_gap_end        = rsp_ff.gap_end;
   assign rsp_first_mismatch = rsp_ff.first_mismatch;
   assign rsp_broken         = rsp_ff.broken;
   assign rsp_error_count    = rsp_ff.error_count;

   // a committed word shows up on the result channel
   a_commit_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("committed word missing from result register");

   // no word in the check stage while the table is being cleared
   a_no_word_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !s1_valid_ff)
      else $error("word in flight during table sweep");

   // a take beside a commit on the same channel is always forwarded
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      (req_take && s1_move && (s1_idx_ff == req_idx)) |=> fwd_hit_ff)
      else $error("same-channel word not forwarded");

endmodule
